// ===== hdl/lpht_pkg.sv =====
package lpht_pkg;

    // table geometry
    localparam int SLOTS      = 128;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int KEY_W      = 31;
    localparam int SLOT_OUT_W = 7;

    // operation codes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_FIND   = 1'b1;

    // result status codes
    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_FOUND     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic             mode;
        logic [KEY_W-1:0] key_id;
    } t_cmd;

    typedef struct packed {
        logic [1:0]            status;
        logic [SLOT_OUT_W-1:0] slot;
    } t_result;

endpackage

// ===== hdl/linear_probe_hash_table_core.sv =====
// Open-addressed key table with linear probing. A command beat (insert or find
// of one key) is taken when start is high and busy is low; exactly one result
// follows on o_result, marked by o_done for a single cycle, and must be
// captured then since the block cannot be held off. The home slot is the low
// bits of the key; probing then checks one slot per clock against the key
// memory (registered read, next address issued while the current slot is
// checked). The deciding probe's result is registered onto o_done/o_result;
// a command ends after at most SLOTS = 128 probes. Busy is already low in the
// o_done cycle, so the next start can be taken at that same edge; no new
// command is taken while one is in flight. Duplicate keys are stored; find
// reports the first match in probe order and stops at the first empty slot.
module linear_probe_hash_table_core
    import lpht_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_cmd    i_cmd,
    output logic    o_done,
    output t_result o_result
);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_PROBE = 1'b1;

    logic                  r_state, n_state;
    logic                  r_mode;
    logic [KEY_W-1:0]      r_key;
    logic [SLOT_W-1:0]     r_ptr, n_ptr;
    logic [SLOT_W-1:0]     r_cnt;
    logic [SLOTS-1:0]      r_valid;
    logic                  r_done;
    t_result               r_result, n_result;
    logic                  n_done;

    logic [KEY_W-1:0]      mem_key [SLOTS];
    logic [KEY_W-1:0]      r_rd_data;
    logic [SLOT_W-1:0]     rd_addr;
    logic                  wr_en;

    logic                  accept;
    logic                  slot_used;
    logic                  last_probe;
    logic [SLOT_W-1:0]     ptr_inc;
    logic [SLOT_W-1:0]     home;

    assign accept     = start && (r_state == S_IDLE);
    assign busy       = (r_state != S_IDLE);
    assign home       = i_cmd.key_id[SLOT_W-1:0];
    assign slot_used  = r_valid[r_ptr];
    assign last_probe = (r_cnt == SLOT_W'(SLOTS - 1));
    assign ptr_inc    = (r_ptr == SLOT_W'(SLOTS - 1)) ? '0 : r_ptr + 1'b1;

    // read address: home slot on accept, next slot while probing
    assign rd_addr = (r_state == S_IDLE) ? home : ptr_inc;

    // probe decision
    always_comb begin
        n_state  = r_state;
        n_ptr    = r_ptr;
        n_done   = 1'b0;
        n_result = r_result;
        wr_en    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_PROBE;
                    n_ptr   = home;
                end
            end
            S_PROBE: begin
                n_ptr = ptr_inc;
                if (r_mode == MODE_INSERT) begin
                    if (!slot_used) begin
                        wr_en    = 1'b1;
                        n_done   = 1'b1;
                        n_result = '{status: ST_INSERTED, slot: SLOT_OUT_W'(r_ptr)};
                    end else if (last_probe) begin
                        n_done   = 1'b1;
                        n_result = '{status: ST_FULL, slot: '0};
                    end
                end else begin
                    if (!slot_used) begin
                        n_done   = 1'b1;
                        n_result = '{status: ST_NOT_FOUND, slot: '0};
                    end else if (r_rd_data == r_key) begin
                        n_done   = 1'b1;
                        n_result = '{status: ST_FOUND, slot: SLOT_OUT_W'(r_ptr)};
                    end else if (last_probe) begin
                        n_done   = 1'b1;
                        n_result = '{status: ST_NOT_FOUND, slot: '0};
                    end
                end
                if (n_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (wr_en) begin
                r_valid[r_ptr] <= 1'b1;
            end
        end
    end

    // command and probe payload
    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_result <= n_result;
        if (accept) begin
            r_mode <= i_cmd.mode;
            r_key  <= i_cmd.key_id;
            r_cnt  <= '0;
        end else begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // key memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_key[r_ptr] <= r_key;
        end
        r_rd_data <= mem_key[rd_addr];
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("done strobe held");

    // busy drops exactly when a result is issued
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy dropped without result");

    // an inserted or found slot is occupied
    a_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == ST_INSERTED || o_result.status == ST_FOUND))
            |-> r_valid[SLOT_W'(o_result.slot)])
        else $error("reported slot is empty");

    // no result without a command in flight
    a_done_after_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state) == S_PROBE)
        else $error("result without probe");

endmodule
